/* hdl/pfan_pkg.sv */
// shared constants and types of the polygon fan triangulator
`default_nettype none
package pfan_pkg;

  // default index width and masks per packed word
  localparam int unsigned IndexBitsDef    = 24;
  localparam int unsigned MasksPerWordDef = 10;

  // one edge-visibility mask
  localparam int unsigned MaskBits = 3;
  localparam int unsigned EdgeNewPrior   = 0;  // current -> previous, always visible
  localparam int unsigned EdgePriorFirst = 1;  // previous -> first, first triangle
  localparam int unsigned EdgeFirstNew   = 2;  // first -> current, last triangle

  // entries of the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // classification of one corner, handed from front to back
  typedef struct packed {
    logic is_tri;     // corner closes a triangle
    logic first_tri;  // it is the polygon's first triangle
    logic last_tri;   // it is the polygon's last triangle
    logic mesh_last;  // corner ends the mesh
  } op_flags_t;

endpackage : pfan_pkg
`default_nettype wire

/* hdl/pfan_fifo.sv */
// small first-in first-out queue between the front and back parts
`default_nettype none
module pfan_fifo import pfan_pkg::*; #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output      logic             push_ready_o,
  input  wire logic [Width-1:0] push_data_i,
  output      logic             pop_valid_o,
  input  wire logic             pop_ready_i,
  output      logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrBits = $clog2(QueueDepth);
  localparam int unsigned CntBits = $clog2(QueueDepth + 1);

  logic [Width-1:0]   mem_q [QueueDepth];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] count_q;
  logic               push, pop;

  assign push_ready_o = (count_q != CntBits'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule : pfan_fifo
`default_nettype wire

/* hdl/pfan_front.sv */
// front part: tracks polygon corners and classifies each corner
`default_nettype none
module pfan_front import pfan_pkg::*; #(
  parameter int unsigned IndexBits = IndexBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire logic [IndexBits-1:0] point_index_i,
  input  wire logic                 polygon_end_i,
  input  wire logic                 mesh_end_i,
  output      logic                 op_valid_o,
  input  wire logic                 op_ready_i,
  output      logic [IndexBits-1:0] op_newest_o,
  output      logic [IndexBits-1:0] op_prior_o,
  output      logic [IndexBits-1:0] op_anchor_o,
  output      op_flags_t            op_flags_o
);

  logic [IndexBits-1:0] anchor_q, prior_q;
  logic [1:0]           count_q;
  logic                 poly_last, accept;

  assign poly_last  = polygon_end_i || mesh_end_i;
  assign in_ready_o = op_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    op_flags_o.is_tri    = count_q[1];
    op_flags_o.first_tri = (count_q == 2'd2);
    op_flags_o.last_tri  = count_q[1] && poly_last;
    op_flags_o.mesh_last = mesh_end_i;
  end

  // corners that make nothing are absorbed here
  assign op_valid_o  = in_valid_i && (count_q[1] || mesh_end_i);
  assign op_newest_o = count_q[1] ? point_index_i : '0;
  assign op_prior_o  = count_q[1] ? prior_q : '0;
  assign op_anchor_o = count_q[1] ? anchor_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      if (poly_last) begin
        count_q <= '0;
      end else if (count_q != 2'd3) begin
        count_q <= count_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (count_q == 2'd0) begin
        anchor_q <= point_index_i;
      end else begin
        prior_q <= point_index_i;
      end
    end
  end

endmodule : pfan_front
`default_nettype wire

/* hdl/pfan_back.sv */
// back part: face counting, mask packing and the output register
`default_nettype none
module pfan_back import pfan_pkg::*; #(
  parameter int unsigned IndexBits    = IndexBitsDef,
  parameter int unsigned MasksPerWord = MasksPerWordDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            op_valid_i,
  output      logic                            op_ready_o,
  input  wire logic [IndexBits-1:0]            op_newest_i,
  input  wire logic [IndexBits-1:0]            op_prior_i,
  input  wire logic [IndexBits-1:0]            op_anchor_i,
  input  wire op_flags_t                       op_flags_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_ready_i,
  output      logic                            tri_valid_o,
  output      logic [IndexBits-1:0]            corner_newest_o,
  output      logic [IndexBits-1:0]            corner_prior_o,
  output      logic [IndexBits-1:0]            corner_anchor_o,
  output      logic [IndexBits-1:0]            face_number_o,
  output      logic                            vis_word_valid_o,
  output      logic [MaskBits*MasksPerWord-1:0] vis_word_o,
  output      logic                            done_res_o
);

  localparam int unsigned WordBits = MaskBits * MasksPerWord;
  localparam int unsigned SlotBits = $clog2(MasksPerWord + 1);

  logic [WordBits-1:0]  acc_q, acc_d, acc_add;
  logic [SlotBits-1:0]  slot_q, slot_d, slot_inc;
  logic [IndexBits-1:0] face_q, face_d;
  logic [MaskBits-1:0]  mask;
  logic                 word_out;
  logic [WordBits-1:0]  word;
  logic                 pop;

  logic                 out_valid_q;
  logic                 tri_q, word_valid_q, done_q;
  logic [IndexBits-1:0] newest_q, prior_q, anchor_q, fnum_q;
  logic [WordBits-1:0]  word_q;

  assign op_ready_o = !out_valid_q || out_ready_i;
  assign pop        = op_valid_i && op_ready_o;

  always_comb begin
    mask                 = '0;
    mask[EdgeNewPrior]   = 1'b1;
    mask[EdgePriorFirst] = op_flags_i.first_tri;
    mask[EdgeFirstNew]   = op_flags_i.last_tri;
    for (int i = 0; i < MasksPerWord; i++) begin
      acc_add[i*MaskBits +: MaskBits] = (slot_q == SlotBits'(i)) ? mask : '0;
    end
    slot_inc = slot_q + 1'b1;

    acc_d    = acc_q;
    slot_d   = slot_q;
    face_d   = face_q;
    word_out = 1'b0;
    word     = '0;
    if (op_flags_i.is_tri) begin
      acc_d  = acc_q | acc_add;
      slot_d = slot_inc;
      if (face_q != '1) begin
        face_d = face_q + 1'b1;
      end
      if (slot_inc == SlotBits'(MasksPerWord)) begin
        word_out = 1'b1;
        word     = acc_d;
        acc_d    = '0;
        slot_d   = '0;
      end
    end
    if (op_flags_i.mesh_last) begin
      // flush a partly filled word
      if (slot_d != '0) begin
        word_out = 1'b1;
        word     = acc_d;
      end
      acc_d  = '0;
      slot_d = '0;
      face_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      slot_q      <= '0;
      face_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        acc_q  <= acc_d;
        slot_q <= slot_d;
        face_q <= face_d;
      end
      if (op_ready_o) begin
        out_valid_q <= op_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      tri_q        <= op_flags_i.is_tri;
      newest_q     <= op_newest_i;
      prior_q      <= op_prior_i;
      anchor_q     <= op_anchor_i;
      fnum_q       <= op_flags_i.is_tri ? face_q : '0;
      word_valid_q <= word_out;
      word_q       <= word;
      done_q       <= op_flags_i.mesh_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign tri_valid_o      = tri_q;
  assign corner_newest_o  = newest_q;
  assign corner_prior_o   = prior_q;
  assign corner_anchor_o  = anchor_q;
  assign face_number_o    = fnum_q;
  assign vis_word_valid_o = word_valid_q;
  assign vis_word_o       = word_q;
  assign done_res_o       = done_q;

endmodule : pfan_back
`default_nettype wire

/* hdl/polygon_fan_triangulator.sv */
// top level of the polygon fan triangulator
//
// Takes one polygon corner per transfer and cuts every polygon into a
// triangle fan: from the third corner on, each corner gives the triangle
// (current, previous, first) plus a 3-bit edge-visibility mask; masks are
// packed MASKS_PER_WORD to a word, oldest in the low bits, and a word goes
// out when full or when the mesh ends. The block sustains one corner per
// clock cycle unless back pressure fills the queue: the front part
// classifies a corner in the cycle it arrives, a two-entry queue decouples
// it from the back part, and the back part updates the face counter and
// the mask word and loads the output register in the cycle it takes a
// corner from the queue. A corner that produces a result passes through
// the queue and then the output register before it reaches the output;
// corners that produce nothing (the first two of a polygon, unless they
// end the mesh) leave no trace at the output. The output register frees
// itself in the cycle it is taken, so back pressure only stops input once
// the queue holds two entries.
`default_nettype none
module polygon_fan_triangulator import pfan_pkg::*; #(
  parameter int unsigned INDEX_BITS     = IndexBitsDef,
  parameter int unsigned MASKS_PER_WORD = MasksPerWordDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // corner input
  input  wire logic                               in_valid_i,
  output      logic                               in_ready_o,
  input  wire logic [INDEX_BITS-1:0]              point_index_i,
  input  wire logic                               polygon_end_i,
  input  wire logic                               mesh_end_i,
  // result output
  output      logic                               out_valid_o,
  input  wire logic                               out_ready_i,
  output      logic                               tri_valid_o,
  output      logic [INDEX_BITS-1:0]              corner_newest_o,
  output      logic [INDEX_BITS-1:0]              corner_prior_o,
  output      logic [INDEX_BITS-1:0]              corner_anchor_o,
  output      logic [INDEX_BITS-1:0]              face_number_o,
  output      logic                               vis_word_valid_o,
  output      logic [MaskBits*MASKS_PER_WORD-1:0] vis_word_o,
  output      logic                               done_res_o
);

  // queue entry: three corners and the classification flags
  localparam int unsigned OpBits = 3 * INDEX_BITS + $bits(op_flags_t);

  logic                  fr_valid, fr_ready;
  logic [INDEX_BITS-1:0] fr_newest, fr_prior, fr_anchor;
  op_flags_t             fr_flags;

  logic                  bk_valid, bk_ready;
  logic [OpBits-1:0]     bk_data;
  logic [INDEX_BITS-1:0] bk_newest, bk_prior, bk_anchor;
  op_flags_t             bk_flags;

  // front: polygon corner tracking
  pfan_front #(
    .IndexBits (INDEX_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .point_index_i (point_index_i),
    .polygon_end_i (polygon_end_i),
    .mesh_end_i    (mesh_end_i),
    .op_valid_o    (fr_valid),
    .op_ready_i    (fr_ready),
    .op_newest_o   (fr_newest),
    .op_prior_o    (fr_prior),
    .op_anchor_o   (fr_anchor),
    .op_flags_o    (fr_flags)
  );

  // decoupling queue
  pfan_fifo #(
    .Width (OpBits)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  ({fr_newest, fr_prior, fr_anchor, fr_flags}),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_data)
  );

  assign {bk_newest, bk_prior, bk_anchor, bk_flags} = bk_data;

  // back: face count, mask packing, output register
  pfan_back #(
    .IndexBits    (INDEX_BITS),
    .MasksPerWord (MASKS_PER_WORD)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_valid_i       (bk_valid),
    .op_ready_o       (bk_ready),
    .op_newest_i      (bk_newest),
    .op_prior_i       (bk_prior),
    .op_anchor_i      (bk_anchor),
    .op_flags_i       (bk_flags),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .tri_valid_o      (tri_valid_o),
    .corner_newest_o  (corner_newest_o),
    .corner_prior_o   (corner_prior_o),
    .corner_anchor_o  (corner_anchor_o),
    .face_number_o    (face_number_o),
    .vis_word_valid_o (vis_word_valid_o),
    .vis_word_o       (vis_word_o),
    .done_res_o       (done_res_o)
  );

  // a result always carries a triangle, a word or the end of the mesh
  a_no_empty_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tri_valid_o && !vis_word_valid_o |-> done_res_o)
    else $error("empty result transferred");

  // corner fields are zero on results without a triangle
  a_zero_corners : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tri_valid_o |-> (corner_newest_o == '0) && (face_number_o == '0))
    else $error("corner fields set without a triangle");

  // every mask has its current->previous edge set, so a word is never zero
  a_word_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && vis_word_valid_o |-> vis_word_o[EdgeNewPrior])
    else $error("packed word lacks its oldest mask");

endmodule : polygon_fan_triangulator
`default_nettype wire
